[hdl/ple_pkg.sv]
// Shared constants for the positional list engine: request modes, status
// codes and the sequencer's walk kinds. No dependencies.
package ple_pkg;

    // Widths fixed by the request and result fields.
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_PASTEND  = 3'd5;

    // Kinds of memory walk run by the sequencer.
    localparam logic [1:0] WALK_UP   = 2'd0;
    localparam logic [1:0] WALK_DOWN = 2'd1;
    localparam logic [1:0] WALK_SRCH = 2'd2;

endpackage

[hdl/ple_ram.sv]
// Simple dual-port RAM for the list entries: one write port, one read port
// with registered read data. No dependencies.
module ple_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[hdl/positional_list_engine_top.sv]
// Positional list engine top level: request decode, walk sequencer and
// result registers. Depends on ple_pkg and ple_ram.
//
// A request is taken when start is high and busy is low. Push back, pop back,
// a push or insert at the current end, a removal of the last element, a search
// of an empty list, the unused mode and all rejected requests finish in the
// cycle they are taken, so the result appears in the next cycle. A positional
// insert, a positional removal, a push front or a pop front moves the tail of
// the list through the entry RAM one entry per cycle. A search reads the
// entries one per cycle from the front and ends at the first match or after
// the last entry. The single read port of the entry RAM sets this pace. The
// result shows on status, found_position and length for exactly one cycle
// while done is high; it cannot be held off, so the receiver must take it
// then. busy drops in that same cycle, and a new request may be issued there.
module positional_list_engine_top
    import ple_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   mode,
    input  logic signed [DATA_W-1:0] value,
    input  logic [POS_W-1:0]    position,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [POS_W-1:0]    found_position,
    output logic [POS_W-1:0]    length
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_PUT   = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]       stop_reg, stop_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;
    logic [AW-1:0]       slot_reg, slot_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [STATUS_W-1:0] hold_st_reg, hold_st_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [POS_W-1:0]    found_reg, found_next;
    logic [POS_W-1:0]    len_reg, len_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [DATA_W-1:0]   ram_rdata;

    // Entry storage.
    ple_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (AW),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Request decode, walk sequencer and result formation.
    always_comb
    begin
        logic [XW-1:0]       pos_x;
        logic [XW-1:0]       cnt_x;
        logic [XW-1:0]       slot_x;
        logic [XW-1:0]       newcnt_x;
        logic [AW-1:0]       slot_a;
        logic [AW-1:0]       last_a;
        logic                full;
        logic                empty;
        logic                do_ins;
        logic                do_rem;
        logic                fin;
        logic [STATUS_W-1:0] fin_st;
        logic [POS_W-1:0]    fin_found;
        logic                matched;

        state_next     = state_reg;
        op_next        = op_reg;
        rd_ptr_next    = rd_ptr_reg;
        stop_next      = stop_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        slot_next      = slot_reg;
        value_next     = value_reg;
        hold_st_next   = hold_st_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        len_next       = len_reg;

        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = value_reg;

        pos_x  = XW'(position);
        cnt_x  = XW'(count_reg);
        slot_x = '0;
        slot_a = '0;
        full   = (cnt_x == XW'(CAPACITY));
        empty  = (count_reg == '0);
        last_a = AW'(cnt_x - XW'(1));
        do_ins = 1'b0;
        do_rem = 1'b0;
        fin       = 1'b0;
        fin_st    = ST_OK;
        fin_found = '0;
        matched   = (ram_rdata == value_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    value_next   = value;
                    hold_st_next = ST_OK;
                    case (mode)
                        MODE_PUSH_FRONT:
                        begin
                            if (full) begin fin = 1'b1; fin_st = ST_FULL; end
                            else do_ins = 1'b1;
                        end
                        MODE_PUSH_BACK:
                        begin
                            if (full) begin fin = 1'b1; fin_st = ST_FULL; end
                            else
                            begin
                                do_ins = 1'b1;
                                slot_x = cnt_x;
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (position == '0)
                            begin
                                fin = 1'b1; fin_st = ST_BADPOS;
                            end
                            else if (full)
                            begin
                                fin = 1'b1; fin_st = ST_FULL;
                            end
                            else if (pos_x > cnt_x + XW'(1))
                            begin
                                do_ins       = 1'b1;
                                slot_x       = cnt_x;
                                hold_st_next = ST_APPENDED;
                            end
                            else
                            begin
                                do_ins = 1'b1;
                                slot_x = pos_x - XW'(1);
                            end
                        end
                        MODE_POP_FRONT:
                        begin
                            if (empty) begin fin = 1'b1; fin_st = ST_EMPTY; end
                            else do_rem = 1'b1;
                        end
                        MODE_POP_BACK:
                        begin
                            if (empty) begin fin = 1'b1; fin_st = ST_EMPTY; end
                            else
                            begin
                                do_rem = 1'b1;
                                slot_x = cnt_x - XW'(1);
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (position == '0)
                            begin
                                fin = 1'b1; fin_st = ST_BADPOS;
                            end
                            else if (empty)
                            begin
                                fin = 1'b1; fin_st = ST_EMPTY;
                            end
                            else if (pos_x > cnt_x)
                            begin
                                fin = 1'b1; fin_st = ST_PASTEND;
                            end
                            else
                            begin
                                do_rem = 1'b1;
                                slot_x = pos_x - XW'(1);
                            end
                        end
                        MODE_SEARCH:
                        begin
                            if (empty) fin = 1'b1;
                            else
                            begin
                                op_next     = WALK_SRCH;
                                rd_ptr_next = '0;
                                stop_next   = last_a;
                                pend_next   = 1'b0;
                                state_next  = S_WALK;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase

                    slot_a    = AW'(slot_x);
                    slot_next = slot_a;

                    // Insert: write directly at the end, or shift the tail up.
                    if (do_ins)
                    begin
                        if (slot_x == cnt_x)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = slot_a;
                            ram_wdata  = value;
                            count_next = count_reg + CW'(1);
                            fin        = 1'b1;
                            fin_st     = hold_st_next;
                        end
                        else
                        begin
                            op_next     = WALK_UP;
                            rd_ptr_next = last_a;
                            stop_next   = slot_a;
                            pend_next   = 1'b0;
                            state_next  = S_WALK;
                        end
                    end

                    // Removal: drop the last element, or shift the tail down.
                    if (do_rem)
                    begin
                        if (slot_x == cnt_x - XW'(1))
                        begin
                            count_next = count_reg - CW'(1);
                            fin        = 1'b1;
                        end
                        else
                        begin
                            op_next     = WALK_DOWN;
                            rd_ptr_next = slot_a + AW'(1);
                            stop_next   = last_a;
                            pend_next   = 1'b0;
                            state_next  = S_WALK;
                        end
                    end
                end
            end

            S_WALK, S_DRAIN:
            begin
                // Retire the entry read in the previous cycle.
                if (pend_reg)
                begin
                    if (op_reg == WALK_SRCH)
                    begin
                        if (matched)
                        begin
                            fin       = 1'b1;
                            fin_found = POS_W'(XW'(pend_addr_reg) + XW'(1));
                        end
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = pend_addr_reg;
                        ram_wdata = ram_rdata;
                    end
                end

                if (state_reg == S_WALK)
                begin
                    // Issue the next read and step the pointer.
                    pend_next = 1'b1;
                    case (op_reg)
                        WALK_UP:   pend_addr_next = rd_ptr_reg + AW'(1);
                        WALK_DOWN: pend_addr_next = rd_ptr_reg - AW'(1);
                        default:   pend_addr_next = rd_ptr_reg;
                    endcase
                    if (rd_ptr_reg == stop_reg)
                    begin
                        state_next = S_DRAIN;
                    end
                    else if (op_reg == WALK_UP)
                    begin
                        rd_ptr_next = rd_ptr_reg - AW'(1);
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + AW'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    case (op_reg)
                        WALK_UP:
                        begin
                            state_next = S_PUT;
                        end
                        WALK_DOWN:
                        begin
                            count_next = count_reg - CW'(1);
                            fin        = 1'b1;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_PUT:
            begin
                // Place the new value into the opened slot.
                ram_we     = 1'b1;
                ram_waddr  = slot_reg;
                ram_wdata  = value_reg;
                count_next = count_reg + CW'(1);
                fin        = 1'b1;
                fin_st     = hold_st_reg;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Finish the request and load the result registers.
        done_next = fin;
        if (fin)
        begin
            state_next  = S_IDLE;
            pend_next   = 1'b0;
            status_next = fin_st;
            found_next  = fin_found;
            newcnt_x    = XW'(count_next);
            len_next    = newcnt_x[POS_W-1:0];
        end
        else
        begin
            newcnt_x = '0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        rd_ptr_reg    <= rd_ptr_next;
        stop_reg      <= stop_next;
        pend_addr_reg <= pend_addr_next;
        slot_reg      <= slot_next;
        value_reg     <= value_next;
        hold_st_reg   <= hold_st_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        len_reg       <= len_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign found_position = found_reg;
    assign length         = len_reg;

endmodule

[verif/positional_list_engine_top_tb.sv]
// Self-checking testbench for positional_list_engine_top: directed corner cases, a full-list
// pass and random request mixes, all scored against a queue-based list predictor.
// Depends on ple_pkg and the engine RTL.
module positional_list_engine_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int LIST_CAPACITY = 64;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    // One predicted result, stamped with the time its request was taken.
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    found;
        logic [POS_W-1:0]    len;
        time                 taken_at;
    } list_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [MODE_W-1:0]       mode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]        position;
    logic                    done;
    logic [STATUS_W-1:0]     status;
    logic [POS_W-1:0]        found_position;
    logic [POS_W-1:0]        length;

    // Predictor state: the list contents in order, front first.
    logic signed [DATA_W-1:0] shadow_list[$];
    list_result_t expected_results[$];
    list_result_t front_result;

    int error_count     = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int search_hits     = 0;
    int sender_idle_pct = 0;
    int status_tally[8];

    positional_list_engine_top #(
        .CAPACITY(LIST_CAPACITY)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .value(value),
        .position(position),
        .done(done),
        .status(status),
        .found_position(found_position),
        .length(length)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input int expected, input int got);
        $display("MISMATCH at %0t: %s expected %0d got %0d", $time, what, expected, got);
        error_count++;
    endtask

    // Apply one request to the shadow list and work out the result it must produce.
    function automatic list_result_t predict_list_result(input logic [MODE_W-1:0] m,
                                                         input logic signed [DATA_W-1:0] v,
                                                         input logic [POS_W-1:0] p);
        list_result_t r;
        int n;
        int j;
        r.status = ST_OK;
        r.found  = '0;
        n = shadow_list.size();
        case (m)
            MODE_PUSH_FRONT:
                if (n >= LIST_CAPACITY) r.status = ST_FULL;
                else shadow_list.push_front(v);
            MODE_PUSH_BACK:
                if (n >= LIST_CAPACITY) r.status = ST_FULL;
                else shadow_list.push_back(v);
            MODE_INSERT:
                if (p == 0) r.status = ST_BADPOS;
                else if (n >= LIST_CAPACITY) r.status = ST_FULL;
                else if (int'(p) > n + 1)
                begin
                    shadow_list.push_back(v);
                    r.status = ST_APPENDED;
                end
                else shadow_list.insert(int'(p) - 1, v);
            MODE_POP_FRONT:
                if (n == 0) r.status = ST_EMPTY;
                else void'(shadow_list.pop_front());
            MODE_POP_BACK:
                if (n == 0) r.status = ST_EMPTY;
                else void'(shadow_list.pop_back());
            MODE_REMOVE:
                if (p == 0) r.status = ST_BADPOS;
                else if (n == 0) r.status = ST_EMPTY;
                else if (int'(p) > n) r.status = ST_PASTEND;
                else shadow_list.delete(int'(p) - 1);
            MODE_SEARCH:
                for (j = 0; j < n && r.found == 0; j++)
                begin
                    if (shadow_list[j] == v) r.found = POS_W'(j + 1);
                end
            default:
                ;
        endcase
        r.len = POS_W'(shadow_list.size());
        r.taken_at = $time;
        return r;
    endfunction

    // Send one request, with a random lead-in gap, and record it once it is taken.
    task automatic send_request(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v,
                                input logic [POS_W-1:0] p);
        int gap;
        list_result_t r;
        gap = 0;
        while (gap < 8 && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0)
        begin
            // Idle cycles carry junk on the request fields.
            start    <= 1'b0;
            mode     <= MODE_W'($urandom);
            value    <= $urandom;
            position <= POS_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        mode     <= m;
        value    <= v;
        position <= p;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        r = predict_list_result(m, v, p);
        expected_results.push_back(r);
        requests_sent++;
        status_tally[r.status]++;
        if (m == MODE_SEARCH && r.found != 0) search_hits++;
    endtask

    // Stop issuing requests and wait until every expected result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    // Value mix: extremes, a small pool that makes duplicates and hits, and full-range noise.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 12)
        begin
            case ($urandom_range(3))
                0: return VALUE_MIN;
                1: return VALUE_MAX;
                2: return '0;
                default: return -1;
            endcase
        end
        if (r < 40) return DATA_W'($urandom_range(7));
        return $urandom;
    endfunction

    // Position mix around the current length n, plus zero and the whole field range.
    function automatic logic [POS_W-1:0] pick_position(input int n);
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 15) return POS_W'($urandom_range(127));
        if (r < 25) return POS_W'(n + $urandom_range(2));
        return POS_W'($urandom_range(n + 1, 1));
    endfunction

    // Score each result against the oldest prediction taken at an earlier edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (expected_results.size() == 0 || expected_results[0].taken_at >= $time)
                report_mismatch("result with no request pending, status", -1, status);
            else
            begin
                front_result = expected_results.pop_front();
                results_checked++;
                if (status !== front_result.status)
                    report_mismatch("status", front_result.status, status);
                if (found_position !== front_result.found)
                    report_mismatch("found_position", front_result.found, found_position);
                if (length !== front_result.len)
                    report_mismatch("length", front_result.len, length);
            end
        end
    end

    // Rejections on an empty list, position zero, a search on nothing and the unused mode.
    task automatic test_empty_list();
        send_request(MODE_POP_FRONT, 32'sd1, 7'd1);
        send_request(MODE_POP_BACK, 32'sd1, 7'd1);
        send_request(MODE_REMOVE, 32'sd1, 7'd1);
        send_request(MODE_REMOVE, 32'sd1, 7'd0);
        send_request(MODE_INSERT, 32'sd1, 7'd0);
        send_request(MODE_SEARCH, 32'sd0, 7'd0);
        send_request(MODE_UNUSED, -1, 7'd127);
    endtask

    // Inserts and removals at the ends and past them, searches with duplicates and misses.
    task automatic test_edge_positions();
        send_request(MODE_PUSH_FRONT, VALUE_MIN, 7'd0);
        send_request(MODE_PUSH_BACK, VALUE_MAX, 7'd0);
        send_request(MODE_INSERT, -1, 7'd2);
        send_request(MODE_INSERT, 32'sd0, 7'd127);
        send_request(MODE_INSERT, 32'sd5, 7'd5);
        send_request(MODE_PUSH_BACK, 32'sd0, 7'd0);
        send_request(MODE_SEARCH, VALUE_MIN, 7'd0);
        send_request(MODE_SEARCH, 32'sd0, 7'd0);
        send_request(MODE_SEARCH, 32'sd1234, 7'd0);
        send_request(MODE_REMOVE, 32'sd0, 7'd127);
        send_request(MODE_REMOVE, 32'sd0, 7'd7);
        send_request(MODE_REMOVE, 32'sd0, 7'd6);
        send_request(MODE_REMOVE, 32'sd0, 7'd2);
        send_request(MODE_REMOVE, 32'sd0, 7'd0);
        send_request(MODE_POP_FRONT, 32'sd0, 7'd0);
        send_request(MODE_POP_BACK, 32'sd0, 7'd0);
        send_request(MODE_SEARCH, VALUE_MAX, 7'd0);
    endtask

    // Fill to capacity, hit every insert on the full list, search deep, then empty it.
    task automatic test_full_list();
        sender_idle_pct = 20;
        while (shadow_list.size() < LIST_CAPACITY)
            send_request($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_value(), '0);
        send_request(MODE_PUSH_FRONT, 32'sd9, 7'd0);
        send_request(MODE_PUSH_BACK, 32'sd9, 7'd0);
        send_request(MODE_INSERT, 32'sd9, 7'd1);
        send_request(MODE_INSERT, 32'sd9, 7'd0);
        send_request(MODE_SEARCH, shadow_list[LIST_CAPACITY-1], 7'd0);
        send_request(MODE_SEARCH, 32'sd12345, 7'd0);
        send_request(MODE_REMOVE, 32'sd0, 7'd65);
        send_request(MODE_REMOVE, 32'sd0, 7'd64);
        send_request(MODE_INSERT, VALUE_MIN, 7'd1);
        while (shadow_list.size() > 0)
            send_request(MODE_REMOVE, 32'sd0, pick_position(shadow_list.size() - 1));
    endtask

    // Random requests whose insert/remove balance drifts so the length sweeps empty to full.
    task automatic run_random_mix(input int n_items, input int idle_pct);
        int grow_pct;
        int r;
        int n;
        int i;
        logic [MODE_W-1:0] m;
        logic signed [DATA_W-1:0] v;
        sender_idle_pct = idle_pct;
        grow_pct = 50;
        for (i = 0; i < n_items; i++)
        begin
            if (i % 48 == 0)
            begin
                r = $urandom_range(2);
                grow_pct = (r == 0) ? 15 : (r == 1) ? 50 : 85;
            end
            n = shadow_list.size();
            r = $urandom_range(99);
            if (r < 3) m = MODE_UNUSED;
            else if (r < 25) m = MODE_SEARCH;
            else if ($urandom_range(99) < grow_pct)
            begin
                r = $urandom_range(2);
                m = (r == 0) ? MODE_PUSH_FRONT : (r == 1) ? MODE_PUSH_BACK : MODE_INSERT;
            end
            else
            begin
                r = $urandom_range(2);
                m = (r == 0) ? MODE_POP_FRONT : (r == 1) ? MODE_POP_BACK : MODE_REMOVE;
            end
            v = pick_value();
            if (m == MODE_SEARCH && n > 0 && $urandom_range(99) < 70)
                v = shadow_list[$urandom_range(n - 1)];
            send_request(m, v, pick_position(n));
        end
    endtask

    // Run limit well above the slowest legal run.
    initial
    begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

    // Reset, then the tests in turn; from the edge-position test on, the sender waits for all results after each test.
    initial
    begin
        rst_n    <= 1'b0;
        start    <= 1'b0;
        mode     <= '0;
        value    <= '0;
        position <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        sender_idle_pct = 38;
        test_empty_list();
        test_edge_positions();
        wait_for_results();
        test_full_list();
        wait_for_results();
        run_random_mix(260, 38);
        wait_for_results();
        run_random_mix(260, 47);
        wait_for_results();
        run_random_mix(260, 0);
        wait_for_results();
        repeat (LIST_CAPACITY + 10) @(posedge clk);

        $display("Covered %0d requests and %0d results: ok %0d, bad position %0d, full %0d,",
                 requests_sent, results_checked, status_tally[ST_OK], status_tally[ST_BADPOS],
                 status_tally[ST_FULL]);
        $display("empty %0d, appended %0d, remove past end %0d, search hits %0d.",
                 status_tally[ST_EMPTY], status_tally[ST_APPENDED], status_tally[ST_PASTEND],
                 search_hits);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
hdl/ple_pkg.sv
hdl/ple_ram.sv
hdl/positional_list_engine_top.sv
verif/positional_list_engine_top_tb.sv
